@@ hdl/sawte_pkg.sv @@
// sawte_pkg: shared types, constants and helpers of the set-associative tag engine
// no dependencies

package sawte_pkg;

    localparam int ADDR_W    = 27;
    localparam int LINE_W    = 6;
    localparam int SET_W     = 12;
    localparam int TAG_W     = ADDR_W - LINE_W - SET_W;
    localparam int WAYS      = 16;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int NUM_SETS  = 1 << SET_W;
    localparam int LFSR_W    = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] set_row_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

@@ hdl/sawte_dp.sv @@
// sawte_dp: set row memory, lookup and allocation logic, replacement lfsr, result registers
// depends on sawte_pkg

module sawte_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sawte_pkg::ctrl_cmd_t          cmd,
    output sawte_pkg::dp_sts_t            sts,
    input  logic                          s_operation,
    input  logic [sawte_pkg::ADDR_W-1:0]  s_address,
    input  logic                          cfg_valid,
    input  logic [sawte_pkg::LFSR_W-1:0]  cfg_replacement_seed,
    output logic                          m_hit,
    output logic [sawte_pkg::WAY_W-1:0]   m_way,
    output logic                          m_fill_needed,
    output logic                          m_writeback_needed,
    output logic [sawte_pkg::TAG_W-1:0]   m_victim_tag
);
    import sawte_pkg::*;

    set_row_t             mem [NUM_SETS];
    set_row_t             row_reg;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic                 op_reg;
    logic [SET_W-1:0]     clr_cnt_reg;
    logic [LFSR_W-1:0]    lfsr_reg;
    logic [LFSR_W-1:0]    lfsr_next_val;

    logic                 hit;
    logic                 full;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     free_way;
    logic [WAY_W-1:0]     vic_way;
    logic [WAY_W-1:0]     way_sel;
    logic                 wb;
    logic [TAG_W-1:0]     vtag;
    set_row_t             new_row;

    logic                 mem_we;
    logic [SET_W-1:0]     wr_addr;
    set_row_t             wr_row;

    // tag lookup over the ways of the set
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        full     = 1'b1;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row_reg[w].valid) begin
                if (!hit && row_reg[w].tag == tag_reg) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end else begin
                full     = 1'b0;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        vic_way = full ? lfsr_reg[WAY_W-1:0] : free_way;
        way_sel = hit ? hit_way : vic_way;
        wb      = !hit && full && row_reg[vic_way].dirty;
        vtag    = wb ? row_reg[vic_way].tag : '0;
        new_row = row_reg;
        if (!hit) begin
            new_row[vic_way].valid = 1'b1;
            new_row[vic_way].dirty = op_reg;
            new_row[vic_way].tag   = tag_reg;
        end else if (op_reg) begin
            new_row[hit_way].dirty = 1'b1;
        end
    end

    assign mem_we  = cmd.clear_wr || cmd.commit;
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : set_reg;
    assign wr_row  = cmd.clear_wr ? set_row_t'('0) : new_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_reg <= mem[s_address[LINE_W +: SET_W]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            set_reg <= s_address[LINE_W +: SET_W];
            tag_reg <= s_address[ADDR_W-1 -: TAG_W];
            op_reg  <= s_operation;
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == SET_W'(NUM_SETS - 1));

    assign lfsr_next_val = lfsr_next(lfsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= SEED_RESET;
        end else if (cfg_valid) begin
            lfsr_reg <= (cfg_replacement_seed == '0) ? LFSR_W'(1) : cfg_replacement_seed;
        end else if (cmd.commit && !hit && full) begin
            lfsr_reg <= lfsr_next_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_hit              <= hit;
            m_way              <= way_sel;
            m_fill_needed      <= !hit;
            m_writeback_needed <= wb;
            m_victim_tag       <= vtag;
        end
    end

endmodule

@@ hdl/sawte_ctrl.sv @@
// sawte_ctrl: controller state machine, clearing pass, input and result handshakes
// depends on sawte_pkg

module sawte_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sawte_pkg::ctrl_cmd_t  cmd,
    input  sawte_pkg::dp_sts_t    sts
);
    import sawte_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted beat did not move to evaluation");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not raise result valid");

    a_eval_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && m_valid_reg && !m_ready) |=> (state_reg == ST_EVAL))
        else $error("evaluation left while result slot busy");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_ready && !cmd.commit))
        else $error("activity during clearing pass");

endmodule

@@ hdl/set_assoc_writeback_tag_engine.sv @@
// set_assoc_writeback_tag_engine: top level of the 16-way write-back cache tag engine
// depends on sawte_pkg, sawte_ctrl, sawte_dp
//
// channel  | handshake            | payload
// s_       | s_valid / s_ready    | s_operation, s_address
// m_       | m_valid / m_ready    | m_hit, m_way, m_fill_needed, m_writeback_needed, m_victim_tag
// cfg_     | cfg_valid / cfg_ready| cfg_replacement_seed
//
// each access reads the set row from the tag memory, then does the lookup and row write back
// after reset a clearing pass writes all 4096 set rows, one per cycle, before any access is taken
// the seed channel is always ready and loads the replacement lfsr
// a held result stalls the evaluation cycle until the result beat is taken

module set_assoc_writeback_tag_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [sawte_pkg::ADDR_W-1:0]  s_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [sawte_pkg::WAY_W-1:0]   m_way,
    output logic                          m_fill_needed,
    output logic                          m_writeback_needed,
    output logic [sawte_pkg::TAG_W-1:0]   m_victim_tag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sawte_pkg::LFSR_W-1:0]  cfg_replacement_seed
);
    import sawte_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    logic      cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    sawte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sawte_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sts                  (sts),
        .s_operation          (s_operation),
        .s_address            (s_address),
        .cfg_valid            (cfg_wr),
        .cfg_replacement_seed (cfg_replacement_seed),
        .m_hit                (m_hit),
        .m_way                (m_way),
        .m_fill_needed        (m_fill_needed),
        .m_writeback_needed   (m_writeback_needed),
        .m_victim_tag         (m_victim_tag)
    );

endmodule
